>>> rtl/tmc_pkg.sv
// Shared types and constants for the text mode console engine.
package tmc_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_WRAP,
    ST_PUT_BODY,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_READ_WAIT,
    ST_READ_DATA,
    ST_RESP
  } eng_state_t;

endpackage

>>> rtl/tmc_if.sv
// Valid/ready channel interfaces for commands and responses.
interface tmc_cmd_if;
  logic          valid;
  logic          ready;
  tmc_pkg::cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface tmc_rsp_if;
  logic          valid;
  logic          ready;
  tmc_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

>>> rtl/tmc_front.sv
// Command front end: saturates targets and queues commands for the engine.
module tmc_front #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic           clk,
  input  logic           rst,
  tmc_cmd_if.sink        cmd,
  output logic           q_valid,
  input  logic           q_pop,
  output tmc_pkg::cmd_t  q_head
);
  localparam logic [6:0] COL_MAX = 7'(SCREEN_WIDTH - 1);
  localparam logic [4:0] ROW_MAX = 5'(SCREEN_HEIGHT - 1);

  tmc_pkg::cmd_t slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;
  tmc_pkg::cmd_t sat;
  logic          push;

  always_comb begin
    sat = cmd.payload;
    if (cmd.payload.col > COL_MAX) sat.col = COL_MAX;
    if (cmd.payload.row > ROW_MAX) sat.row = ROW_MAX;
  end

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_head    = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(q_pop);
    end
    if (push) slot[wp] <= sat;
  end
endmodule

>>> rtl/tmc_back.sv
// Command engine: owns the cell memory, cursor and scroll/clear sweeps.
module tmc_back #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  tmc_pkg::cmd_t  q_head,
  tmc_rsp_if.source      rsp
);
  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SHIFT  = AW'(CELLS - SCREEN_WIDTH);
  localparam logic [AW-1:0] WIDTHA = AW'(SCREEN_WIDTH);
  localparam logic [6:0] WIDTHC  = 7'(SCREEN_WIDTH);
  localparam logic [4:0] LASTROW = 5'(SCREEN_HEIGHT - 1);

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  tmc_pkg::eng_state_t state, state_next;
  tmc_pkg::cmd_t cur;
  logic [7:0]    attr;
  logic [6:0]    ccol;
  logic [4:0]    crow;
  logic [AW-1:0] base;
  logic [AW-1:0] ptr;
  logic          scr;
  logic          body_done;
  logic [7:0]    rchar;
  logic [7:0]    rattr;
  logic [10:0]   lin;
  logic          rsp_valid;
  tmc_pkg::rsp_t rsp_reg;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tmc_pkg::ST_INIT:      if (ptr == LAST) state_next = tmc_pkg::ST_IDLE;
      tmc_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.op)
            tmc_pkg::OP_PUT:   state_next = tmc_pkg::ST_PUT_WRAP;
            tmc_pkg::OP_MOVE:  state_next = tmc_pkg::ST_RESP;
            tmc_pkg::OP_CLEAR: state_next = tmc_pkg::ST_FILL;
            tmc_pkg::OP_READ:  state_next = tmc_pkg::ST_READ_WAIT;
          endcase
        end
      end
      tmc_pkg::ST_PUT_WRAP: begin
        if (ccol >= WIDTHC && crow == LASTROW) state_next = tmc_pkg::ST_SCROLL_RD;
        else state_next = tmc_pkg::ST_PUT_BODY;
      end
      tmc_pkg::ST_PUT_BODY: begin
        if (cur.char_code == tmc_pkg::CH_NEWLINE && crow == LASTROW)
          state_next = tmc_pkg::ST_SCROLL_RD;
        else state_next = tmc_pkg::ST_RESP;
      end
      tmc_pkg::ST_SCROLL_RD: state_next = tmc_pkg::ST_SCROLL_WR;
      tmc_pkg::ST_SCROLL_WR: begin
        if (ptr == LAST) state_next = body_done ? tmc_pkg::ST_RESP : tmc_pkg::ST_PUT_BODY;
        else if (ptr >= SHIFT - AW'(1)) state_next = tmc_pkg::ST_SCROLL_WR;
        else state_next = tmc_pkg::ST_SCROLL_RD;
      end
      tmc_pkg::ST_FILL:      if (ptr == LAST) state_next = tmc_pkg::ST_RESP;
      tmc_pkg::ST_READ_WAIT: state_next = tmc_pkg::ST_READ_DATA;
      tmc_pkg::ST_READ_DATA: state_next = tmc_pkg::ST_RESP;
      tmc_pkg::ST_RESP:      if (!rsp_valid || rsp.ready) state_next = tmc_pkg::ST_IDLE;
      default:               state_next = tmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = ptr;
    wr_data = {attr, tmc_pkg::CH_SPACE};
    rd_addr = ptr + WIDTHA;
    q_pop   = (state == tmc_pkg::ST_IDLE) && q_valid;
    unique case (state)
      tmc_pkg::ST_INIT: begin
        mem_we  = 1'b1;
        wr_data = {tmc_pkg::ATTR_RESET, tmc_pkg::CH_SPACE};
      end
      tmc_pkg::ST_PUT_BODY: begin
        if (cur.char_code != tmc_pkg::CH_NEWLINE && cur.char_code != tmc_pkg::CH_RETURN) begin
          mem_we  = 1'b1;
          wr_addr = base + AW'(ccol);
          wr_data = {attr, cur.char_code};
        end
      end
      tmc_pkg::ST_SCROLL_WR: begin
        mem_we = 1'b1;
        if (ptr < SHIFT) wr_data = rd_data;
      end
      tmc_pkg::ST_FILL: mem_we = 1'b1;
      tmc_pkg::ST_READ_WAIT: rd_addr = base + AW'(cur.col);
      default: ;
    endcase
  end

  assign lin = 11'(crow * SCREEN_WIDTH) + 11'(ccol);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmc_pkg::ST_INIT;
      attr      <= tmc_pkg::ATTR_RESET;
      ccol      <= '0;
      crow      <= '0;
      base      <= '0;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) attr <= cfg_data;
      if (state == tmc_pkg::ST_RESP && (!rsp_valid || rsp.ready)) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        tmc_pkg::ST_INIT: ptr <= ptr + AW'(1);
        tmc_pkg::ST_IDLE: begin
          if (q_valid) begin
            cur       <= q_head;
            scr       <= 1'b0;
            body_done <= 1'b0;
            rchar     <= '0;
            rattr     <= '0;
            ptr       <= '0;
            if (q_head.op == tmc_pkg::OP_READ)
              base <= AW'(q_head.row * SCREEN_WIDTH);
            if (q_head.op == tmc_pkg::OP_MOVE) begin
              ccol <= q_head.col;
              crow <= q_head.row;
              base <= AW'(q_head.row * SCREEN_WIDTH);
            end
            if (q_head.op == tmc_pkg::OP_CLEAR) begin
              ccol <= '0;
              crow <= '0;
              base <= '0;
            end
          end
        end
        tmc_pkg::ST_PUT_WRAP: begin
          if (ccol >= WIDTHC) begin
            ccol <= '0;
            if (crow == LASTROW) scr <= 1'b1;
            else begin
              crow <= crow + 5'd1;
              base <= base + WIDTHA;
            end
          end
        end
        tmc_pkg::ST_PUT_BODY: begin
          body_done <= 1'b1;
          if (cur.char_code == tmc_pkg::CH_NEWLINE) begin
            ccol <= '0;
            if (crow == LASTROW) scr <= 1'b1;
            else begin
              crow <= crow + 5'd1;
              base <= base + WIDTHA;
            end
          end else if (cur.char_code == tmc_pkg::CH_RETURN) begin
            ccol <= '0;
          end else begin
            ccol <= ccol + 7'd1;
          end
        end
        tmc_pkg::ST_SCROLL_WR: ptr <= (ptr == LAST) ? '0 : ptr + AW'(1);
        tmc_pkg::ST_FILL:      ptr <= ptr + AW'(1);
        tmc_pkg::ST_READ_DATA: begin
          rchar <= rd_data[7:0];
          rattr <= rd_data[15:8];
          base  <= AW'(crow * SCREEN_WIDTH);
        end
        tmc_pkg::ST_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_reg <= '{cursor_col: ccol, cursor_row: crow, cursor_linear: lin,
                         read_char: rchar, read_attr: rattr, scrolled: scr};
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_reg;
endmodule

>>> rtl/text_mode_console_engine.sv
// Top level of the text mode console engine.
// Commands arrive on the cmd channel and each one yields exactly one
// response on the rsp channel, in order. A request is accepted when
// valid and ready are both high. A two-entry queue separates the command
// front end from the engine, so commands are taken while the engine works.
// The text attribute register (attr) is written through cfg_we and cfg_data.
// After reset the engine writes blank cells into the whole grid before
// it starts on the first command. The engine works on one command at a
// time; a clear writes every cell of the grid in turn. A scroll moves
// every row up by one, one read and one write per moved cell, and blanks
// the last row. The response sits in an output register; if the
// receiver stalls, the engine holds the next response and the queue
// fills before cmd.ready drops.
module text_mode_console_engine #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  tmc_cmd_if.sink    cmd,
  tmc_rsp_if.source  rsp
);
  logic          q_valid;
  logic          q_pop;
  tmc_pkg::cmd_t q_head;

  tmc_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk(clk), .rst(rst), .cmd(cmd),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  tmc_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head), .rsp(rsp)
  );
endmodule
